/* src/matrix_multiply_assert.svh */
// Assertion macros shared by the matrix multiply checker.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("matrix_multiply: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("matrix_multiply: next-cycle check failed");

`endif

/* src/mm_pkg.sv */
// Types and constants shared by the matrix multiply modules.
package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int DATA_W    = 16;
    localparam int SUM_W     = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 3;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        KIND_LOAD_A  = 2'd0,
        KIND_LOAD_B  = 2'd1,
        KIND_COMPUTE = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_M  = 2'd0,
        CFG_INNER_K = 2'd1,
        CFG_COLS_N  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_kind                     kind;
        logic [COORD_W-1:0]        row_index;
        logic [COORD_W-1:0]        col_index;
        logic signed [DATA_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0]       out_row;
        logic [COORD_W-1:0]       out_col;
        logic signed [SUM_W-1:0]  dot_sum;
        logic                     last_of_run;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic start_run;
        logic start_elem;
        logic issue;
        logic emit;
    } t_mm_cmd;

    typedef struct packed {
        logic run_empty;
        logic k_zero;
        logic t_last;
        logic elem_last;
        logic pipe_busy;
        logic out_free;
    } t_mm_status;

endpackage

/* src/mm_ctrl.sv */
// Controller state machine that sequences loads and compute runs.
module mm_ctrl
    import mm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_kind      i_in_kind,
    output logic       o_in_ready,
    input  t_mm_status i_status,
    output t_mm_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.accept     = i_in_valid && (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && (i_in_kind == KIND_COMPUTE) && !i_status.run_empty) begin
                    o_cmd.start_run  = 1'b1;
                    o_cmd.start_elem = 1'b1;
                    n_state          = i_status.k_zero ? S_DRAIN : S_READ;
                end
            end
            S_READ: begin
                o_cmd.issue = 1'b1;
                if (i_status.t_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.start_elem = 1'b1;
                        n_state          = i_status.k_zero ? S_DRAIN : S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/mm_datapath.sv */
// Datapath with the two element stores, index counters, multiply-accumulate and output register.
module mm_datapath
    import mm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_rows_m,
    input  logic [CFG_W-1:0] i_inner_k,
    input  logic [CFG_W-1:0] i_cols_n,
    input  t_in_item         i_item,
    input  t_mm_cmd          i_cmd,
    output t_mm_status       o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int ACC_W = SUM_W + IDX_W + 1;

    logic [DIM_W-1:0] m_eff;
    logic [DIM_W-1:0] k_eff;
    logic [DIM_W-1:0] n_eff;

    logic signed [DATA_W-1:0] r_mem_a [DEPTH];
    logic signed [DATA_W-1:0] r_mem_b [DEPTH];
    logic [DEPTH-1:0]         r_vld_a;
    logic [DEPTH-1:0]         r_vld_b;

    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_t;

    logic signed [DATA_W-1:0] r_rd_a;
    logic signed [DATA_W-1:0] r_rd_b;
    logic                     r_rd_a_ok;
    logic                     r_rd_b_ok;
    logic                     r_p1;
    logic signed [SUM_W-1:0]  r_prod;
    logic                     r_p2;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic [AW-1:0]            waddr;
    logic                     we_a;
    logic                     we_b;
    logic [AW-1:0]            raddr_a;
    logic [AW-1:0]            raddr_b;
    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic [ACC_W-SUM_W:0]     acc_top;
    logic signed [SUM_W-1:0]  sat_sum;
    logic                     row_end;

    // Register values above the store size act as the store size.
    assign m_eff = (CW'(i_rows_m) > CW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(i_rows_m);
    assign k_eff = (CW'(i_inner_k) > CW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(i_inner_k);
    assign n_eff = (CW'(i_cols_n) > CW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(i_cols_n);

    assign waddr = AW'(AW'(i_item.row_index) * AW'(MAX_DIM) + AW'(i_item.col_index));
    assign we_a  = i_cmd.accept && (i_item.kind == KIND_LOAD_A)
                && (CW'(i_item.row_index) < CW'(m_eff))
                && (CW'(i_item.col_index) < CW'(k_eff));
    assign we_b  = i_cmd.accept && (i_item.kind == KIND_LOAD_B)
                && (CW'(i_item.row_index) < CW'(k_eff))
                && (CW'(i_item.col_index) < CW'(n_eff));

    assign raddr_a = AW'(AW'(r_i) * AW'(MAX_DIM) + AW'(r_t));
    assign raddr_b = AW'(AW'(r_t) * AW'(MAX_DIM) + AW'(r_j));

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[waddr] <= i_item.value;
        end
        if (we_b) begin
            r_mem_b[waddr] <= i_item.value;
        end
        if (i_cmd.issue) begin
            r_rd_a <= r_mem_a[raddr_a];
            r_rd_b <= r_mem_b[raddr_b];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a   <= '0;
            r_vld_b   <= '0;
            r_rd_a_ok <= 1'b0;
            r_rd_b_ok <= 1'b0;
        end else begin
            if (we_a) begin
                r_vld_a[waddr] <= 1'b1;
            end
            if (we_b) begin
                r_vld_b[waddr] <= 1'b1;
            end
            if (i_cmd.issue) begin
                r_rd_a_ok <= r_vld_a[raddr_a];
                r_rd_b_ok <= r_vld_b[raddr_b];
            end
        end
    end

    assign row_end = (DIM_W'(r_j) == DIM_W'(n_eff - 1'b1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_t <= '0;
        end else begin
            if (i_cmd.start_run) begin
                r_i <= '0;
                r_j <= '0;
            end else if (i_cmd.emit) begin
                if (row_end) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (i_cmd.start_elem) begin
                r_t <= '0;
            end else if (i_cmd.issue) begin
                r_t <= r_t + 1'b1;
            end
        end
    end

    assign op_a = r_rd_a_ok ? r_rd_a : '0;
    assign op_b = r_rd_b_ok ? r_rd_b : '0;

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1  <= 1'b0;
            r_p2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_p1 <= i_cmd.issue;
            r_p2 <= r_p1;
            if (i_cmd.start_elem) begin
                r_acc <= '0;
            end else if (r_p2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign acc_top = r_acc[ACC_W-1:SUM_W-1];

    always_comb begin
        if ((&acc_top) || !(|acc_top)) begin
            sat_sum = r_acc[SUM_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            sat_sum = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            sat_sum = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.out_row     <= COORD_W'(r_i);
            r_out_item.out_col     <= COORD_W'(r_j);
            r_out_item.dot_sum     <= sat_sum;
            r_out_item.last_of_run <= o_status.elem_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign o_status.run_empty = (m_eff == '0) || (n_eff == '0);
    assign o_status.k_zero    = (k_eff == '0);
    assign o_status.t_last    = (DIM_W'(r_t) == DIM_W'(k_eff - 1'b1));
    assign o_status.elem_last = (DIM_W'(r_i) == DIM_W'(m_eff - 1'b1)) && row_end;
    assign o_status.pipe_busy = r_p1 || r_p2;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

/* src/matrix_multiply.sv */
// Top level of the matrix multiply block: shape registers, controller and datapath.
//
// Items of kind load A and load B write one signed Q8.8 element of matrix A or B;
// loads outside the configured shape are dropped. A compute item emits
// rows_m * cols_n results in row-major order, each a Q16.16 dot product
// saturated to 32 bits, with last_of_run set on the final one. One shared
// multiply-accumulate walks the inner dimension for each result in turn.
// Input items are not taken while a run is in progress. Both stores read as
// zero after reset without any clearing pass, and the shape registers reset
// to 8 and may only be written while the block is idle.
module matrix_multiply
    import mm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item
);

    logic [CFG_W-1:0] r_rows_m;
    logic [CFG_W-1:0] r_inner_k;
    logic [CFG_W-1:0] r_cols_n;

    t_mm_cmd    cmd;
    t_mm_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m  <= CFG_DIM_RESET;
            r_inner_k <= CFG_DIM_RESET;
            r_cols_n  <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ROWS_M:  r_rows_m  <= i_cfg_data;
                CFG_INNER_K: r_inner_k <= i_cfg_data;
                CFG_COLS_N:  r_cols_n  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_item.kind),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rows_m    (r_rows_m),
        .i_inner_k   (r_inner_k),
        .i_cols_n    (r_cols_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* src/mm_checker.sv */
// Port-level checker for the matrix multiply block and its bind statement.
`include "matrix_multiply_assert.svh"

module mm_checker
    import mm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t_in_item             i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_item            o_out_item
);

    // A stalled result item keeps its value.
    `MM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // While a run still has results to come, no new item is taken.
    `MM_ASSERT_SAME(a_busy_in_run, i_clk, i_rst_n, o_out_valid && !o_out_item.last_of_run, !o_in_ready)

    // A load item never starts a run, so the block stays open for the next item.
    `MM_ASSERT_NEXT(a_load_ready, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_item.kind == KIND_LOAD_A || i_in_item.kind == KIND_LOAD_B), o_in_ready)

    // Reset leaves the block idle with no result pending.
    `MM_ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);
